/* src/rchp_pkg.sv */
// Shared constants and types for the RIFF chunk header parser.
`default_nettype none

package rchp_pkg;

  // Little-endian "RIFF" magic as read from bytes 0..3
  localparam logic [31:0] RIFF_MAGIC       = 32'h4646_4952;
  localparam logic [31:0] SAT32            = 32'hFFFF_FFFF;
  localparam logic [31:0] FILE_HEADER_LEN  = 32'd12;
  localparam logic [31:0] CHUNK_HEADER_LEN = 32'd8;
  localparam logic [31:0] MAGIC_LAST_POS   = 32'd3;
  localparam logic [31:0] FORM_LAST_POS    = FILE_HEADER_LEN - 32'd1;
  localparam logic [31:0] FIRST_PAYLOAD_AT = FILE_HEADER_LEN + CHUNK_HEADER_LEN;

  typedef logic [1:0]  phase_t;
  typedef logic [1:0]  kind_t;
  typedef logic [31:0] word_t;

  // Parse phase codes
  localparam phase_t PHASE_FILE   = 2'd0;
  localparam phase_t PHASE_CHUNKS = 2'd1;
  localparam phase_t PHASE_IGNORE = 2'd2;
  localparam phase_t PHASE_SPARE  = 2'd3;

  // Event kind codes
  localparam kind_t KIND_FORM   = 2'd0;
  localparam kind_t KIND_CHUNK  = 2'd1;
  localparam kind_t KIND_NOT_RIFF = 2'd2;
  localparam kind_t KIND_UNUSED = 2'd3;

endpackage

`default_nettype wire

/* src/riff_chunk_header_parser.sv */
// RIFF chunk header parser: byte stream in, form word and chunk header events out.
// A result is in the output register in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; the input stalls only while a result waits to be taken.
// The whole step for a byte is one pass of compares and one 33-bit add before the registers.
// Reset (rst, synchronous): file-start state, byte 0 next, padding off, output empty.
// No clearing pass is needed after reset.
`default_nettype none

module riff_chunk_header_parser import rchp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [31:0]      word_value,
  output logic [31:0]      chunk_length,
  output logic [31:0]      payload_offset
);

  logic        pad_odd_sizes;
  word_t       byte_position, byte_position_next;
  word_t       next_header_at, next_header_at_next;
  word_t       payload_at;
  logic [3:0]  header_byte_index, header_byte_index_next;
  logic [63:0] header_shift, header_shift_next;
  phase_t      parse_phase, parse_phase_next;

  // Effective state after an optional file start
  word_t       cur_pos;
  word_t       cur_nha;
  logic [3:0]  cur_hbi;
  phase_t      cur_phase;
  logic [63:0] shifted;
  logic [3:0]  hbi_inc;
  logic        collecting;
  logic [32:0] next_sum;
  logic        pad_bit;

  logic        emit;
  kind_t       emit_kind;
  word_t       emit_word;
  word_t       emit_length;
  word_t       emit_offset;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Apply a file start ahead of the byte itself
  always_comb begin
    cur_pos   = stream_start ? '0 : byte_position;
    cur_nha   = stream_start ? FILE_HEADER_LEN : next_header_at;
    cur_hbi   = stream_start ? '0 : header_byte_index;
    cur_phase = stream_start ? PHASE_FILE : parse_phase;
  end

  assign shifted    = {data_byte, header_shift[63:8]};
  assign hbi_inc    = cur_hbi + 4'd1;
  assign collecting = (cur_hbi != '0) || ((cur_pos == cur_nha) && (cur_nha != SAT32));
  assign pad_bit    = pad_odd_sizes && shifted[32];
  // Next header lies after the payload, padded to even when enabled
  assign next_sum   = {1'b0, payload_at} + {1'b0, shifted[63:32]} + {32'd0, pad_bit};

  // Per-byte parse step
  always_comb begin
    header_shift_next      = header_shift;
    header_byte_index_next = cur_hbi;
    next_header_at_next    = cur_nha;
    parse_phase_next       = cur_phase;
    byte_position_next     = (cur_pos == SAT32) ? SAT32 : cur_pos + 32'd1;
    emit        = 1'b0;
    emit_kind   = KIND_FORM;
    emit_word   = shifted[63:32];
    emit_length = '0;
    emit_offset = '0;
    unique case (cur_phase)
      PHASE_FILE: begin
        header_shift_next = shifted;
        if (cur_pos == MAGIC_LAST_POS) begin
          if (shifted[63:32] != RIFF_MAGIC) begin
            emit             = 1'b1;
            emit_kind        = KIND_NOT_RIFF;
            parse_phase_next = PHASE_IGNORE;
          end
        end else if (cur_pos == FORM_LAST_POS) begin
          emit                   = 1'b1;
          emit_kind              = KIND_FORM;
          parse_phase_next       = PHASE_CHUNKS;
          header_byte_index_next = '0;
        end
      end
      PHASE_CHUNKS: begin
        if (collecting) begin
          header_shift_next      = shifted;
          header_byte_index_next = hbi_inc;
          if (hbi_inc[3]) begin
            emit                   = 1'b1;
            emit_kind              = KIND_CHUNK;
            emit_word              = shifted[31:0];
            emit_length            = shifted[63:32];
            emit_offset            = payload_at;
            next_header_at_next    = next_sum[32] ? SAT32 : next_sum[31:0];
            header_byte_index_next = '0;
          end
        end
      end
      PHASE_IGNORE, PHASE_SPARE: begin
        header_shift_next = header_shift;
      end
      default: begin
        header_shift_next = header_shift;
      end
    endcase
  end

  // Hold the padding mode
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_odd_sizes <= 1'b0;
    end else if (cfg_write_en) begin
      pad_odd_sizes <= cfg_write_data;
    end
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      next_header_at    <= FILE_HEADER_LEN;
      header_byte_index <= '0;
      parse_phase       <= PHASE_FILE;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      next_header_at    <= next_header_at_next;
      header_byte_index <= header_byte_index_next;
      parse_phase       <= parse_phase_next;
    end
  end

  // Shift bytes in; old contents are always overwritten before use
  always_ff @(posedge clk) begin
    if (accept) begin
      header_shift <= header_shift_next;
    end
  end

  // Track the payload offset of the next header; a header needs eight
  // more items after any change of next_header_at, so the lag of this register is hidden
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_at <= FIRST_PAYLOAD_AT;
    end else if (next_header_at > SAT32 - CHUNK_HEADER_LEN) begin
      payload_at <= SAT32;
    end else begin
      payload_at <= next_header_at + CHUNK_HEADER_LEN;
    end
  end

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      event_kind     <= emit_kind;
      word_value     <= emit_word;
      chunk_length   <= emit_length;
      payload_offset <= emit_offset;
    end
  end

endmodule

`default_nettype wire

/* src/rchp_checker.sv */
// Port-level checker for the RIFF chunk header parser, bound to the top level.
`default_nettype none

module rchp_checker import rchp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  event_kind,
  input wire logic [31:0] word_value,
  input wire logic [31:0] chunk_length,
  input wire logic [31:0] payload_offset
);

  // A waiting result holds its kind and word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(event_kind))
    else $error("result changed while stalled");

  // An empty output never stalls the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Only chunk events carry size and offset
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != KIND_CHUNK |-> chunk_length == '0 && payload_offset == '0)
    else $error("non-chunk event with size or offset");

  // A chunk payload never starts before the first header plus its length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_CHUNK |-> payload_offset >= FIRST_PAYLOAD_AT)
    else $error("chunk payload offset too small");

  // The unused event code never appears
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind != KIND_UNUSED)
    else $error("unused event code");

endmodule

bind riff_chunk_header_parser rchp_checker u_rchp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .event_kind     (event_kind),
  .word_value     (word_value),
  .chunk_length   (chunk_length),
  .payload_offset (payload_offset)
);

`default_nettype wire

/* sim/riff_chunk_header_parser_tb.sv */
// Self-checking testbench for the RIFF chunk header parser: random byte streams, handshake stalls.
`timescale 1ns / 100ps

module riff_chunk_header_parser_tb;
  import rchp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_item_t;

  typedef struct packed {
    kind_t kind;
    word_t fourcc;
    word_t chunk_size;
    word_t payload_at;
  } parse_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        stream_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [31:0] word_value;
  logic [31:0] chunk_length;
  logic [31:0] payload_offset;

  // Parser state as the testbench sees it, reset to a file start
  word_t        byte_pos = '0;
  word_t        hdr_due = FILE_HEADER_LEN;
  logic [3:0]   hdr_count = '0;
  logic [63:0]  hdr_bytes = '0;
  phase_t       parse_state = PHASE_FILE;
  logic         pad_now = 1'b0;

  stream_item_t pending_bytes[$];
  parse_event_t expected_events[$];
  parse_event_t due_event;
  stream_item_t fed;
  int           in_wait = 0;
  int           out_wait = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;
  int           mismatch_count = 0;
  int           bytes_queued = 0;

  riff_chunk_header_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .stream_start   (stream_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .word_value     (word_value),
    .chunk_length   (chunk_length),
    .payload_offset (payload_offset)
  );

  always #6 clk = ~clk;

  function automatic word_t sat_sum(word_t a, word_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  // Advance the parser by one byte and queue the event it raises, if any
  task automatic parse_byte(logic [7:0] b, logic start);
    parse_event_t ev;
    logic [32:0]  reach;
    word_t        poff;
    bit           raised;
    raised = 1'b0;
    if (start) begin
      byte_pos    = '0;
      hdr_due     = FILE_HEADER_LEN;
      hdr_count   = '0;
      hdr_bytes   = '0;
      parse_state = PHASE_FILE;
    end
    if (parse_state == PHASE_FILE) begin
      hdr_bytes = {b, hdr_bytes[63:8]};
      if (byte_pos == MAGIC_LAST_POS) begin
        if (hdr_bytes[63:32] != RIFF_MAGIC) begin
          ev = '{kind: KIND_NOT_RIFF, fourcc: hdr_bytes[63:32], chunk_size: '0, payload_at: '0};
          raised = 1'b1;
          parse_state = PHASE_IGNORE;
        end
      end else if (byte_pos == FORM_LAST_POS) begin
        ev = '{kind: KIND_FORM, fourcc: hdr_bytes[63:32], chunk_size: '0, payload_at: '0};
        raised = 1'b1;
        parse_state = PHASE_CHUNKS;
        hdr_count = '0;
        hdr_bytes = '0;
      end
    end else if (parse_state == PHASE_CHUNKS) begin
      if (hdr_count != 0 || (byte_pos == hdr_due && hdr_due != SAT32)) begin
        hdr_bytes = {b, hdr_bytes[63:8]};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= CHUNK_HEADER_LEN[3:0]) begin
          poff = sat_sum(hdr_due, CHUNK_HEADER_LEN);
          ev = '{kind: KIND_CHUNK, fourcc: hdr_bytes[31:0], chunk_size: hdr_bytes[63:32],
                 payload_at: poff};
          raised = 1'b1;
          // next header lies past the payload, padded to even when asked
          reach = {1'b0, poff} + {1'b0, hdr_bytes[63:32]} + 33'(pad_now & hdr_bytes[32]);
          hdr_due = reach[32] ? SAT32 : reach[31:0];
          hdr_count = '0;
          hdr_bytes = '0;
        end
      end
    end
    byte_pos = sat_sum(byte_pos, 32'd1);
    if (raised) expected_events.push_back(ev);
  endtask

  task automatic check_field(string name, word_t want, word_t seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // Driver: present queued bytes, idle a random number of cycles after each item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte, stream_start);
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 11);
      end
      if (!in_valid || in_ready) begin
        if (in_wait == 0 && pending_bytes.size() != 0) begin
          fed = pending_bytes.pop_front();
          data_byte    <= fed.data;
          stream_start <= fed.start;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest expected event, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d word %h size %h offset %h",
                   $time, event_kind, word_value, chunk_length, payload_offset);
          mismatch_count++;
        end else begin
          due_event = expected_events.pop_front();
          check_field("event_kind", word_t'(due_event.kind), word_t'(event_kind));
          check_field("word_value", due_event.fourcc, word_value);
          check_field("chunk_length", due_event.chunk_size, chunk_length);
          check_field("payload_offset", due_event.payload_at, payload_offset);
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (out_wait == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_wait--;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic start);
    pending_bytes.push_back('{data: b, start: start});
    bytes_queued++;
  endtask

  // Queue a little-endian word, start flag on its first byte only
  task automatic push_word(word_t w, logic start);
    push_byte(w[7:0], start);
    push_byte(w[15:8], 1'b0);
    push_byte(w[23:16], 1'b0);
    push_byte(w[31:24], 1'b0);
  endtask

  task automatic push_noise(int n);
    repeat (n) push_byte(8'($urandom), 1'b0);
  endtask

  // Queue one file: mostly well formed, sometimes bad magic, cut short or off-size payload
  task automatic gen_file();
    word_t magic;
    word_t len;
    int    chunks;
    int    pay;
    magic = RIFF_MAGIC;
    case ($urandom_range(0, 7))
      0: magic = $urandom;
      1: magic = RIFF_MAGIC ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    // an unflagged first byte runs on from whatever came before
    push_word(magic, $urandom_range(0, 7) != 0);
    push_word($urandom, 1'b0);
    push_word($urandom, 1'b0);
    chunks = $urandom_range(0, 4);
    repeat (chunks) begin
      // cut a header short so the next start lands mid-header
      if ($urandom_range(0, 9) == 0) begin
        push_noise($urandom_range(1, 7));
        return;
      end
      push_word($urandom, 1'b0);
      case ($urandom_range(0, 15))
        0: len = SAT32 - $urandom_range(0, 1);
        1: len = $urandom | 32'h8000_0000;
        default: len = $urandom_range(0, 9);
      endcase
      push_word(len, 1'b0);
      // huge chunk: next header lies far past the file, the rest of the file is skipped
      if (len[31]) begin
        push_noise($urandom_range(0, 3));
        return;
      end
      pay = int'(len) + ((pad_now && len[0]) ? 1 : 0);
      case ($urandom_range(0, 9))
        0: pay++;
        1: if (pay > 0) pay--;
        default: ;
      endcase
      push_noise(pay);
    end
  endtask

  // Hold until every byte is taken and every expected event has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_padding(logic pad);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= pad;
    pad_now = pad;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin
    int round;
    int quota;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // No start flag since reset, extreme size bytes, form word, then a chunk whose
    // size saturates the next header position
    push_word(RIFF_MAGIC, 1'b0);
    push_word(32'hFF00_FF00, 1'b0);
    push_word(32'h4556_4157, 1'b0);
    push_word(32'h2074_6D66, 1'b0);
    push_word(SAT32, 1'b0);
    // new file with bad magic, then a byte that is ignored
    push_word(32'h00FF_00FF, 1'b1);
    push_byte(8'h80, 1'b0);
    wait_idle();

    // Random files under padding on, off, on
    for (round = 0; round < 3; round++) begin
      set_padding(round % 2 == 0);
      quota = bytes_queued + 125;
      while (bytes_queued < quota) begin
        gen_file();
        // stray bytes between files, some flagged as a start
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("riff_chunk_header_parser test passed");
    end else begin
      $display("riff_chunk_header_parser test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("riff_chunk_header_parser test failed");
    $finish;
  end

endmodule

/* files.f */
src/rchp_pkg.sv
src/riff_chunk_header_parser.sv
src/rchp_checker.sv
sim/riff_chunk_header_parser_tb.sv
